// ===== hdl/tlpt_pkg.sv =====
package tlpt_pkg;

    // Address split of a 32-bit virtual address
    localparam int unsigned ADDR_W            = 32;
    localparam int unsigned FLAG_W            = 12;
    localparam int unsigned DIR_IDX_W         = 10;
    localparam int unsigned TBL_IDX_W         = 10;
    localparam int unsigned DIR_ENTRIES       = 1024;
    localparam int unsigned ENTRIES_PER_TABLE = 1024;

    // Entry flag bits
    localparam int unsigned BIT_PRESENT = 0;
    localparam int unsigned BIT_WRITE   = 1;

    // Directory flags after reset: not present, writable
    localparam logic [FLAG_W-1:0] DIR_RESET_FLAGS = 12'h002;
    localparam logic [ADDR_W-1:0] FRAME_MASK      = 32'hFFFF_F000;

    // Packed stream widths
    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned STATUS_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_MAP    = 2'd0,
        OP_UNMAP  = 2'd1,
        OP_XLATE  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_MISALIGNED = 2'd1,
        ST_NO_TABLE   = 2'd2,
        ST_EXHAUSTED  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_DIR   = 2'd2,
        S_POOL  = 2'd3
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_en;     // sweep one directory and one pool entry
        logic req_load;   // capture request, read directory
        logic pool_rd;    // read page entry
        logic commit;     // write page entry / directory, bump allocator
        logic out_load;   // load result register
        logic from_pool;  // result comes from the page entry lookup
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_done;   // last entry of the sweep is being written
        logic need_pool;  // request needs the page entry
    } t_dp_sts;

endpackage

// ===== hdl/tlpt_ctrl.sv =====
module tlpt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    output logic               o_req_ready,
    output logic               o_rsp_valid,
    input  logic               i_rsp_ready,
    input  tlpt_pkg::t_dp_sts  i_sts,
    output tlpt_pkg::t_ctl_cmd o_cmd
);

    tlpt_pkg::t_state r_state, n_state;
    logic             r_rsp_valid;
    logic             out_free;

    assign out_free    = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_req_ready = (r_state == tlpt_pkg::S_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tlpt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            tlpt_pkg::S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = tlpt_pkg::S_DIR;
                end
            end
            tlpt_pkg::S_DIR: begin
                if (i_sts.need_pool) begin
                    o_cmd.pool_rd = 1'b1;
                    n_state       = tlpt_pkg::S_POOL;
                end else if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = tlpt_pkg::S_IDLE;
                end
            end
            tlpt_pkg::S_POOL: begin
                if (out_free) begin
                    o_cmd.commit    = 1'b1;
                    o_cmd.out_load  = 1'b1;
                    o_cmd.from_pool = 1'b1;
                    n_state         = tlpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tlpt_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/tlpt_dpath.sv =====
module tlpt_dpath #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tlpt_pkg::t_ctl_cmd                  i_cmd,
    output tlpt_pkg::t_dp_sts                   o_sts,
    input  logic [tlpt_pkg::OP_W-1:0]           i_op,
    input  logic [tlpt_pkg::ADDR_W-1:0]         i_vaddr,
    input  logic [tlpt_pkg::ADDR_W-1:0]         i_frame_addr,
    input  logic [tlpt_pkg::FLAG_W-1:0]         i_entry_flags,
    input  logic [tlpt_pkg::FLAG_W-1:0]         i_dir_flags,
    output logic [tlpt_pkg::STATUS_W-1:0]       o_status,
    output logic [tlpt_pkg::ADDR_W-1:0]         o_frame_out,
    output logic                                o_readable,
    output logic                                o_writable,
    output logic                                o_was_mapped
);

    localparam int unsigned SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned NF_W       = $clog2(TABLE_SLOTS + 1);
    localparam int unsigned DIR_W      = tlpt_pkg::FLAG_W + SLOT_W;
    localparam int unsigned POOL_DEPTH = TABLE_SLOTS * tlpt_pkg::ENTRIES_PER_TABLE;
    localparam int unsigned POOL_AW    = SLOT_W + tlpt_pkg::TBL_IDX_W;

    logic [DIR_W-1:0]          r_dir_mem [0:tlpt_pkg::DIR_ENTRIES-1];
    logic [tlpt_pkg::ADDR_W-1:0] r_pool_mem [0:POOL_DEPTH-1];

    // Captured request
    logic [tlpt_pkg::OP_W-1:0]   r_op;
    logic [tlpt_pkg::ADDR_W-1:0] r_va;
    logic [tlpt_pkg::ADDR_W-1:0] r_fa;
    logic [tlpt_pkg::FLAG_W-1:0] r_ef;
    logic [tlpt_pkg::FLAG_W-1:0] r_df;

    logic [DIR_W-1:0]            r_de;
    logic [tlpt_pkg::ADDR_W-1:0] r_pe;
    logic [POOL_AW-1:0]          r_pool_addr;
    logic                        r_alloc;
    logic [NF_W-1:0]             r_next_free;
    logic [POOL_AW-1:0]          r_clr_cnt;

    logic [tlpt_pkg::DIR_IDX_W-1:0] di;
    logic                        misaligned;
    logic                        present;
    logic                        exhausted;
    logic [SLOT_W-1:0]           slot;
    logic [POOL_AW-1:0]          pool_addr;
    logic [tlpt_pkg::STATUS_W-1:0] early_status;
    logic                        need_pool;

    // Pool result
    logic [tlpt_pkg::STATUS_W-1:0] pool_status;
    logic [tlpt_pkg::ADDR_W-1:0]   pool_frame;
    logic                          pool_rd_ok;
    logic                          pool_wr_ok;
    logic                          pool_was;
    logic                          pool_we;
    logic [tlpt_pkg::ADDR_W-1:0]   pool_wdata;

    assign di = r_va[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_IDX_W];

    // Decode the directory lookup
    always_comb begin
        misaligned = (r_va[tlpt_pkg::FLAG_W-1:0] != '0) ||
                     ((r_op == tlpt_pkg::OP_MAP) && (r_fa[tlpt_pkg::FLAG_W-1:0] != '0));
        present    = r_de[tlpt_pkg::BIT_PRESENT];
        exhausted  = (r_next_free == NF_W'(TABLE_SLOTS));
        slot       = present ? r_de[tlpt_pkg::FLAG_W +: SLOT_W] : r_next_free[SLOT_W-1:0];
        pool_addr  = {slot, r_va[tlpt_pkg::FLAG_W +: tlpt_pkg::TBL_IDX_W]};
        early_status = tlpt_pkg::ST_OK;
        need_pool    = 1'b0;
        case (r_op)
            tlpt_pkg::OP_MAP: begin
                if (misaligned) begin
                    early_status = tlpt_pkg::ST_MISALIGNED;
                end else if (!present && exhausted) begin
                    early_status = tlpt_pkg::ST_EXHAUSTED;
                end else begin
                    need_pool = 1'b1;
                end
            end
            tlpt_pkg::OP_UNMAP, tlpt_pkg::OP_XLATE: begin
                if (misaligned) begin
                    early_status = tlpt_pkg::ST_MISALIGNED;
                end else if (!present) begin
                    early_status = tlpt_pkg::ST_NO_TABLE;
                end else begin
                    need_pool = 1'b1;
                end
            end
            default: begin
                early_status = tlpt_pkg::ST_OK;
            end
        endcase
    end

    assign o_sts.need_pool = need_pool;
    assign o_sts.clr_done  = (r_clr_cnt == POOL_AW'(POOL_DEPTH - 1));

    // Evaluate the page entry
    always_comb begin
        pool_status = tlpt_pkg::ST_OK;
        pool_frame  = '0;
        pool_rd_ok  = 1'b0;
        pool_wr_ok  = 1'b0;
        pool_was    = 1'b0;
        pool_we     = 1'b0;
        pool_wdata  = '0;
        case (r_op)
            tlpt_pkg::OP_MAP: begin
                pool_was   = r_pe[tlpt_pkg::BIT_PRESENT];
                pool_we    = 1'b1;
                pool_wdata = r_fa | {{(tlpt_pkg::ADDR_W - tlpt_pkg::FLAG_W){1'b0}}, r_ef};
            end
            tlpt_pkg::OP_UNMAP: begin
                pool_frame = r_pe & tlpt_pkg::FRAME_MASK;
                pool_we    = 1'b1;
            end
            tlpt_pkg::OP_XLATE: begin
                pool_frame = r_pe & tlpt_pkg::FRAME_MASK;
                pool_rd_ok = r_pe[tlpt_pkg::BIT_PRESENT];
                pool_wr_ok = r_pe[tlpt_pkg::BIT_PRESENT] & r_de[tlpt_pkg::BIT_WRITE] &
                             r_pe[tlpt_pkg::BIT_WRITE];
            end
            default: begin
                pool_we = 1'b0;
            end
        endcase
    end

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_op <= i_op;
            r_va <= i_vaddr;
            r_fa <= i_frame_addr;
            r_ef <= i_entry_flags;
            r_df <= i_dir_flags;
        end
        if (i_cmd.pool_rd) begin
            r_pool_addr <= pool_addr;
            r_alloc     <= (r_op == tlpt_pkg::OP_MAP) && !present;
        end
    end

    // Clearing sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_en && !o_sts.clr_done) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
        end
    end

    // Advance the table allocator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= '0;
        end else if (i_cmd.commit && r_alloc) begin
            r_next_free <= r_next_free + 1'b1;
        end
    end

    // Directory memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_dir_mem[r_clr_cnt[tlpt_pkg::DIR_IDX_W-1:0]] <=
                {{SLOT_W{1'b0}}, tlpt_pkg::DIR_RESET_FLAGS};
        end else if (i_cmd.commit && r_alloc) begin
            r_dir_mem[di] <= {r_next_free[SLOT_W-1:0], r_df};
        end
        if (i_cmd.req_load) begin
            r_de <= r_dir_mem[i_vaddr[tlpt_pkg::ADDR_W-1 -: tlpt_pkg::DIR_IDX_W]];
        end
    end

    // Page table pool memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_pool_mem[r_clr_cnt] <= '0;
        end else if (i_cmd.commit && pool_we) begin
            r_pool_mem[r_pool_addr] <= pool_wdata;
        end
        if (i_cmd.pool_rd) begin
            r_pe <= r_pool_mem[pool_addr];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.from_pool) begin
                o_status     <= pool_status;
                o_frame_out  <= pool_frame;
                o_readable   <= pool_rd_ok;
                o_writable   <= pool_wr_ok;
                o_was_mapped <= pool_was;
            end else begin
                o_status     <= early_status;
                o_frame_out  <= '0;
                o_readable   <= 1'b0;
                o_writable   <= 1'b0;
                o_was_mapped <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/two_level_page_table_engine_top.sv =====
// Two-level page table engine: a 1024-entry page directory and a pool of
// TABLE_SLOTS page tables of 1024 entries each, kept in on-chip memories.
// Each request maps, unmaps or translates one 4 KiB page and returns one
// result. After reset the engine sweeps both memories to their reset
// contents, one directory and one pool entry per cycle, with
// s_axis_tready low. Requests are then handled one at a time: a
// request that reaches its page entry passes through accept, directory
// read, and page entry read and update; one ended early by an error
// status or the unused op skips the page entry step. The steps follow from
// the two dependent synchronous memory reads, directory first, then pool.
// A finished result waits in the output register and the next request is
// taken while it waits; the engine stalls only when a second result is
// ready before the first one was taken.
module two_level_page_table_engine_top #(
    parameter int unsigned TABLE_SLOTS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vaddr[31:0], frame_addr[63:32], entry_flags[75:64],
    // dir_flags[87:76]
    input  logic [tlpt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op[1:0]
    input  logic [tlpt_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status[1:0], frame_out[33:2], readable[34], writable[35],
    // was_mapped[36], zero[39:37]
    output logic [tlpt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    tlpt_pkg::t_ctl_cmd cmd;
    tlpt_pkg::t_dp_sts  sts;

    logic [tlpt_pkg::STATUS_W-1:0] status;
    logic [tlpt_pkg::ADDR_W-1:0]   frame_out;
    logic                          readable;
    logic                          writable;
    logic                          was_mapped;

    tlpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_rsp_valid (m_axis_tvalid),
        .i_rsp_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tlpt_dpath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (s_axis_tuser),
        .i_vaddr       (s_axis_tdata[31:0]),
        .i_frame_addr  (s_axis_tdata[63:32]),
        .i_entry_flags (s_axis_tdata[75:64]),
        .i_dir_flags   (s_axis_tdata[87:76]),
        .o_status      (status),
        .o_frame_out   (frame_out),
        .o_readable    (readable),
        .o_writable    (writable),
        .o_was_mapped  (was_mapped)
    );

    // Pack the result
    assign m_axis_tdata = {3'b000, was_mapped, writable, readable, frame_out, status};

endmodule

// ===== hdl/tlpt_checker.sv =====
module tlpt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [tlpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [tlpt_pkg::OP_W-1:0]        s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tlpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result dropped or changed");

    // One request in flight: no accept right after an accept
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    // Error results carry no frame and no flags
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != tlpt_pkg::ST_OK) |->
            (m_axis_tdata[39:2] == '0))
        else $error("error result with nonzero fields");

    // Write permission implies read permission
    a_wr_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[35] |-> m_axis_tdata[34])
        else $error("writable without readable");

    // A page cannot be both translated and reported as previously mapped
    a_was_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[36] |-> !m_axis_tdata[34] &&
            (m_axis_tdata[33:2] == '0))
        else $error("map result carries translate fields");

endmodule

bind two_level_page_table_engine_top tlpt_checker u_tlpt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/two_level_page_table_engine_top_tb.sv =====
`timescale 1ns / 100ps

module two_level_page_table_engine_top_tb;
    import tlpt_pkg::*;

    localparam int unsigned TABLE_SLOTS = 16;
    localparam int unsigned SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int unsigned DIR_W       = SLOT_W + FLAG_W;
    // memory sweep after reset plus generous slack for stalls
    localparam int unsigned QUIET_LIMIT = 4 * TABLE_SLOTS * ENTRIES_PER_TABLE + 20000;
    localparam int unsigned RANDOM_REQS = 850;
    localparam int unsigned IDLE_PCT    = 23;

    typedef struct {
        t_status     status;
        logic [31:0] frame;
        logic        readable;
        logic        writable;
        logic        was_mapped;
    } t_walk_result;

    typedef struct {
        t_op          op;
        logic [31:0]  va;
        logic [31:0]  fa;
        logic [11:0]  ef;
        logic [11:0]  df;
        bit           typed;
        t_walk_result want;
    } t_page_req;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // shadow copy of the directory, the table pool and the allocator
    logic [DIR_W-1:0]  dir_shadow [DIR_ENTRIES];
    logic [31:0]       pool_shadow [TABLE_SLOTS * ENTRIES_PER_TABLE];
    int unsigned       tables_taken;

    t_page_req    req_list [$];
    t_walk_result pending_walks [$];
    logic [9:0]   hot_dirs [14];
    logic [9:0]   hot_tis [8];

    int unsigned next_item;
    int unsigned err_cnt;
    int unsigned quiet_cycles;
    int unsigned op_cnt [4];
    int unsigned status_cnt [4];
    logic        calm_run;

    assign calm_run = (next_item >= 300) && (next_item < 450);

    two_level_page_table_engine_top #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // reset, held low and then released
    initial begin
        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Walk the shadow tables for one request and update them like the engine.
    function automatic t_walk_result walk_tables(input t_page_req rq);
        t_walk_result     res;
        logic [9:0]       di;
        logic [9:0]       ti;
        logic [DIR_W-1:0] de;
        logic [31:0]      pte;
        int unsigned      pidx;
        res.status     = ST_OK;
        res.frame      = 32'd0;
        res.readable   = 1'b0;
        res.writable   = 1'b0;
        res.was_mapped = 1'b0;
        di = rq.va[31:22];
        ti = rq.va[21:12];
        de = dir_shadow[di];
        if (rq.op == OP_UNUSED) begin
            // nothing happens
        end else if (rq.va[11:0] != 12'd0 || (rq.op == OP_MAP && rq.fa[11:0] != 12'd0)) begin
            res.status = ST_MISALIGNED;
        end else if (rq.op == OP_MAP) begin
            if (!de[BIT_PRESENT] && tables_taken >= TABLE_SLOTS) begin
                res.status = ST_EXHAUSTED;
            end else begin
                // take a fresh table when the slot has none present
                if (!de[BIT_PRESENT]) begin
                    de = {tables_taken[SLOT_W-1:0], rq.df};
                    dir_shadow[di] = de;
                    tables_taken++;
                end
                pidx = de[FLAG_W +: SLOT_W] * ENTRIES_PER_TABLE + ti;
                res.was_mapped = pool_shadow[pidx][BIT_PRESENT];
                pool_shadow[pidx] = rq.fa | {20'd0, rq.ef};
            end
        end else if (!de[BIT_PRESENT]) begin
            res.status = ST_NO_TABLE;
        end else begin
            pidx = de[FLAG_W +: SLOT_W] * ENTRIES_PER_TABLE + ti;
            pte = pool_shadow[pidx];
            res.frame = pte & FRAME_MASK;
            if (rq.op == OP_UNMAP) begin
                pool_shadow[pidx] = 32'd0;
            end else begin
                res.readable = pte[BIT_PRESENT];
                res.writable = pte[BIT_PRESENT] & de[BIT_WRITE] & pte[BIT_WRITE];
            end
        end
        return res;
    endfunction

    task automatic add_row(input t_op op, input logic [31:0] va, input logic [31:0] fa,
                           input logic [11:0] ef, input logic [11:0] df, input bit typed,
                           input t_status st, input logic [31:0] frame,
                           input bit rd, input bit wr, input bit was);
        t_page_req rq;
        rq.op              = op;
        rq.va              = va;
        rq.fa              = fa;
        rq.ef              = ef;
        rq.df              = df;
        rq.typed           = typed;
        rq.want.status     = st;
        rq.want.frame      = frame;
        rq.want.readable   = rd;
        rq.want.writable   = wr;
        rq.want.was_mapped = was;
        req_list.insert(req_list.size(), rq);
    endtask

    // Mostly well-formed requests on a few hot directory slots and page
    // indexes, so that maps, unmaps and translates keep meeting each other.
    task automatic add_random_requests(input int unsigned count);
        int unsigned pick;
        t_op         op;
        logic [31:0] va;
        logic [31:0] fa;
        logic [11:0] ef;
        logic [11:0] df;
        logic [9:0]  di;
        logic [9:0]  ti;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            di = ($urandom_range(99) < 92) ? hot_dirs[$urandom_range(13)]
                                           : 10'($urandom_range(1023));
            ti = ($urandom_range(99) < 75) ? hot_tis[$urandom_range(7)]
                                           : 10'($urandom_range(1023));
            va = {di, ti, 12'h000};
            fa = $urandom & FRAME_MASK;
            ef = 12'($urandom_range(4095));
            df = 12'($urandom_range(4095));
            if ($urandom_range(99) < 80) ef[BIT_PRESENT] = 1'b1;
            if ($urandom_range(99) < 90) df[BIT_PRESENT] = 1'b1;
            if (pick < 40) begin
                op = OP_MAP;
            end else if (pick < 55) begin
                op = OP_UNMAP;
            end else if (pick < 90) begin
                op = OP_XLATE;
            end else if (pick < 97) begin
                // break the alignment of the page or of the frame
                op = t_op'(OP_W'($urandom_range(2)));
                if (op == OP_MAP && $urandom_range(1) == 1)
                    fa[11:0] = 12'($urandom_range(4095, 1));
                else
                    va[11:0] = 12'($urandom_range(4095, 1));
            end else begin
                op = OP_UNUSED;
                va = $urandom;
                fa = $urandom;
            end
            add_row(op, va, fa, ef, df, 1'b0, ST_OK, 32'd0, 1'b0, 1'b0, 1'b0);
        end
    endtask

    // Advance the shadow tables and queue the expected result.
    task automatic take_request(input t_page_req rq);
        t_walk_result res;
        res = walk_tables(rq);
        if (rq.typed)
            res = rq.want;
        op_cnt[rq.op]++;
        status_cnt[res.status]++;
        pending_walks.insert(pending_walks.size(), res);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_cnt++;
        end
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] beat);
        t_walk_result want;
        if (pending_walks.size() == 0) begin
            $error("result 0x%0h arrived with no request pending", beat);
            err_cnt++;
        end else begin
            want = pending_walks.pop_front();
            check_field("status", 32'(want.status), 32'(beat[1:0]));
            check_field("frame_out", want.frame, beat[33:2]);
            check_field("readable", 32'(want.readable), 32'(beat[34]));
            check_field("writable", 32'(want.writable), 32'(beat[35]));
            check_field("was_mapped", 32'(want.was_mapped), 32'(beat[36]));
            check_field("pad", 32'd0, 32'(beat[39:37]));
        end
    endtask

    // request side
    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_MAP;
        next_item     = 0;
        err_cnt       = 0;
        tables_taken  = 0;
        for (int i = 0; i < 4; i++) begin
            op_cnt[i]     = 0;
            status_cnt[i] = 0;
        end
        for (int i = 0; i < DIR_ENTRIES; i++)
            dir_shadow[i] = {{SLOT_W{1'b0}}, DIR_RESET_FLAGS};
        for (int i = 0; i < TABLE_SLOTS * ENTRIES_PER_TABLE; i++)
            pool_shadow[i] = 32'd0;
        hot_dirs = '{10'd0, 10'd1, 10'd1023, 10'd2, 10'd3, 10'd5, 10'd8,
                     10'd13, 10'd100, 10'd200, 10'd300, 10'd511, 10'd512, 10'd777};
        hot_tis  = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd512, 10'd1022, 10'd1023};

        // directed table: op, virt, frame, entry flags, dir flags, typed, expected
        add_row(OP_XLATE,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_NO_TABLE,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_UNMAP,  32'hFFFF_F000, 32'h0,          12'h000, 12'h000, 1'b1, ST_NO_TABLE,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_MAP,    32'h0000_1001, 32'h0000_2000,  12'h003, 12'h003, 1'b1, ST_MISALIGNED,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_MAP,    32'h0000_0000, 32'h0000_0800,  12'h003, 12'h003, 1'b1, ST_MISALIGNED,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'hFFFF_FFFF, 32'h0,          12'h000, 12'h000, 1'b1, ST_MISALIGNED,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  12'hFFF, 12'hFFF, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        // first map takes a table; remap reports the old entry
        add_row(OP_MAP,    32'h0000_0000, 32'hFFFF_F000,  12'hFFF, 12'h003, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'hFFFF_F000, 1'b1, 1'b1, 1'b0);
        add_row(OP_MAP,    32'h0000_0000, 32'h1234_5000,  12'h001, 12'hFFF, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b1);
        add_row(OP_XLATE,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h1234_5000, 1'b1, 1'b0, 1'b0);
        add_row(OP_UNMAP,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h1234_5000, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_UNMAP,  32'h0000_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        // read-only directory entry masks the page write bit
        add_row(OP_MAP,    32'hFFFF_F000, 32'h0000_0000,  12'h003, 12'h001, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'hFFFF_F000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b1, 1'b0, 1'b0);
        // new directory entry without present bit: table spent, slot stays absent
        add_row(OP_MAP,    32'h0040_0000, 32'hABCD_E000,  12'h003, 12'h002, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'h0040_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_NO_TABLE,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_MAP,    32'h0040_0000, 32'h5555_5000,  12'h003, 12'h003, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'h0040_0000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h5555_5000, 1'b1, 1'b1, 1'b0);
        add_row(OP_XLATE,  32'h003F_F000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        // page entry written without present bit
        add_row(OP_MAP,    32'h0000_2000, 32'hFFFF_F000,  12'h000, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_row(OP_XLATE,  32'h0000_2000, 32'h0,          12'h000, 12'h000, 1'b1, ST_OK,
                32'hFFFF_F000, 1'b0, 1'b0, 1'b0);
        add_row(OP_MAP,    32'h0000_2000, 32'h0000_1000,  12'h002, 12'h000, 1'b1, ST_OK,
                32'h0, 1'b0, 1'b0, 1'b0);
        add_random_requests(RANDOM_REQS);

        while (!i_rst_n) @(posedge i_clk);

        // offer requests, holding each until it is taken
        while (next_item < req_list.size()) begin
            @(posedge i_clk);
            if (s_axis_tvalid && s_axis_tready) begin
                take_request(req_list[next_item]);
                next_item++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (next_item < req_list.size() &&
                    (calm_run || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {req_list[next_item].df, req_list[next_item].ef,
                                      req_list[next_item].fa, req_list[next_item].va};
                    s_axis_tuser  <= req_list[next_item].op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end

        // drain, then let the engine settle
        while (pending_walks.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests: %0d map, %0d unmap, %0d translate, %0d unused op",
                 next_item, op_cnt[OP_MAP], op_cnt[OP_UNMAP], op_cnt[OP_XLATE],
                 op_cnt[OP_UNUSED]);
        $display("statuses: %0d ok, %0d misaligned, %0d no table, %0d pool exhausted",
                 status_cnt[ST_OK], status_cnt[ST_MISALIGNED], status_cnt[ST_NO_TABLE],
                 status_cnt[ST_EXHAUSTED]);
        if (err_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // result side with random back-pressure
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            m_axis_tready <= calm_run || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog: stop when nothing moves for too long
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
